// ----- rtl/kscv_pkg.sv -----
// Shared types, constants and coefficient helper for the RGBA 3x3 convolution filter.
`timescale 1ns / 1ps
package kscv_pkg;

  localparam int CHAN_W = 8;
  localparam int PIX_W = 32;
  localparam int ACC_W = 20;       // nine 8x8 signed products fit in 20 bits
  localparam int DEN_W = 12;       // sum of nine signed bytes
  localparam int H_W = 13;         // image height and row counter
  localparam int HEIGHT_LIMIT = 4096;
  localparam int IW_W = 11;        // image_width register
  localparam int KROW_W = 24;      // one kernel row register
  localparam int TAPS = 9;
  localparam int TAP_W = 4;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef logic [PIX_W-1:0] pixel_t;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KERNEL_TOP = 3'd2;
  localparam logic [2:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [2:0] REG_KERNEL_BOTTOM = 3'd4;

  // Pick one signed coefficient, row-major from the top left
  function automatic logic signed [CHAN_W-1:0] coef(input logic [KROW_W-1:0] top_row,
                                                    input logic [KROW_W-1:0] mid_row,
                                                    input logic [KROW_W-1:0] bot_row,
                                                    input logic [TAP_W-1:0] k);
    logic [CHAN_W-1:0] b;
    case (k)
      4'd0: b = top_row[7:0];
      4'd1: b = top_row[15:8];
      4'd2: b = top_row[23:16];
      4'd3: b = mid_row[7:0];
      4'd4: b = mid_row[15:8];
      4'd5: b = mid_row[23:16];
      4'd6: b = bot_row[7:0];
      4'd7: b = bot_row[15:8];
      4'd8: b = bot_row[23:16];
      default: b = '0;
    endcase
    return $signed(b);
  endfunction

endpackage

// ----- rtl/kscv_if.sv -----
// Valid/ready stream interfaces for input pixels and result pixels.
`timescale 1ns / 1ps
interface kscv_in_if
  import kscv_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;
  logic [CHAN_W-1:0] alpha_in;

  modport source(output valid, mode, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink(input valid, mode, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface kscv_out_if
  import kscv_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic [CHAN_W-1:0] alpha_out;
  logic              frame_end;

  modport source(output valid, red_out, green_out, blue_out, alpha_out, frame_end,
                 input ready);
  modport sink(input valid, red_out, green_out, blue_out, alpha_out, frame_end,
               output ready);
endinterface

// ----- rtl/kscv_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module kscv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/kernel_sum_normalized_convolution_top.sv -----
// Top level of the streaming RGBA 3x3 convolution filter with kernel-sum normalization.
`timescale 1ns / 1ps
// The block takes RGBA pixels in raster order and returns each pixel filtered by the
// configured 3x3 signed kernel, divided by the kernel's coefficient sum (toward zero,
// a zero sum divides by 1) and clamped to 0..255; first and last rows and columns pass
// through. Results trail the input by image_width+1 pixels, and drain items (mode 1)
// push out the pending results after the last pixel; frame_end marks the last one.
// One item is in flight at a time. An item that yields no result passes through the
// line-store read and the update before the next transfer is possible; a border pixel
// adds the output load, and a drain that must step twice repeats the read and update.
// An interior pixel adds the multiply-accumulate over the taps (four channels in
// parallel) and the bit-serial division. A stalled output adds the stall. The two line
// stores are synchronous RAMs of MAX_WIDTH entries read and written at the current
// column; they need no clearing pass after reset. Writing image_width or image_height
// in the idle state restarts the stream.
module kernel_sum_normalized_convolution_top
  import kscv_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  kscv_in_if.sink             pix_i,
  kscv_out_if.source          pix_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int NW = WW + H_W;
  localparam int PW = WW + 1;
  localparam int DCW = $clog2(ACC_W);
  localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int RST_TOTAL = RST_W * 480;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ADV,
    S_MAC,
    S_DIV,
    S_OUT
  } state_e;

  // Configuration registers
  logic [IW_W-1:0]   image_width_q;
  logic [H_W-1:0]    image_height_q;
  logic [KROW_W-1:0] ktop_q, kmid_q, kbot_q;
  logic              cfg_wr;
  logic              size_wr;

  logic [WW-1:0]     eff_w_d, eff_w_q;
  logic [H_W-1:0]    eff_h_d, eff_h_q;
  logic [NW-1:0]     total_q;
  logic signed [DEN_W-1:0] den_d, den_q;
  logic [DEN_W-1:0]  dmag_q;

  // Stream state
  state_e            state_q;
  logic [CW-1:0]     col_q;
  logic [H_W-1:0]    row_q;
  logic [NW-1:0]     n_q;
  logic [PW-1:0]     pend_q;
  logic              drain_q, try_q, last_q;
  pixel_t            pix_q, res_q;
  pixel_t            win_q [TAPS];

  // Filter datapath
  logic [TAP_W-1:0]        k_q;
  logic signed [ACC_W-1:0] acc_q [4];
  logic signed [ACC_W-1:0] acc_nx [4];
  logic [ACC_W-1:0]        dvd_q [4];
  logic [ACC_W-1:0]        dvd_nx [4];
  logic [DEN_W-1:0]        rem_q [4];
  logic [DEN_W-1:0]        rem_nx [4];
  logic                    neg_q [4];
  logic [DCW-1:0]          dcnt_q;
  logic signed [CHAN_W-1:0] kc;
  pixel_t                  div_res;

  // Output register
  logic   out_valid_q, out_last_q;
  pixel_t out_data_q;

  // Line stores
  pixel_t up_rd, mid_rd, up_wd, mid_wd;
  logic   mem_we;

  // Advance-step decode
  logic          in_xfer, is_pix, valid_res, border, wrap;
  logic [PW-1:0] pend_nx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign size_wr = cfg_wr && (paddr[4:2] == REG_IMAGE_WIDTH ||
                              paddr[4:2] == REG_IMAGE_HEIGHT);

  // Readback
  always_comb begin
    unique case (paddr[4:2])
      REG_IMAGE_WIDTH:   prdata = DATA_W'(image_width_q);
      REG_IMAGE_HEIGHT:  prdata = DATA_W'(image_height_q);
      REG_KERNEL_TOP:    prdata = DATA_W'(ktop_q);
      REG_KERNEL_MIDDLE: prdata = DATA_W'(kmid_q);
      REG_KERNEL_BOTTOM: prdata = DATA_W'(kbot_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IW_W'(640);
      image_height_q <= H_W'(480);
      ktop_q         <= KROW_W'(24'h010101);
      kmid_q         <= KROW_W'(24'h010101);
      kbot_q         <= KROW_W'(24'h010101);
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_IMAGE_WIDTH:   image_width_q <= pwdata[IW_W-1:0];
        REG_IMAGE_HEIGHT:  image_height_q <= pwdata[H_W-1:0];
        REG_KERNEL_TOP:    ktop_q <= pwdata[KROW_W-1:0];
        REG_KERNEL_MIDDLE: kmid_q <= pwdata[KROW_W-1:0];
        REG_KERNEL_BOTTOM: kbot_q <= pwdata[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size and kernel sum
  always_comb begin
    if (image_width_q == '0) begin
      eff_w_d = WW'(1);
    end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
      eff_w_d = WW'(MAX_WIDTH);
    end else begin
      eff_w_d = WW'(image_width_q);
    end
    if (image_height_q == '0) begin
      eff_h_d = H_W'(1);
    end else if (32'(image_height_q) > 32'(HEIGHT_LIMIT)) begin
      eff_h_d = H_W'(HEIGHT_LIMIT);
    end else begin
      eff_h_d = image_height_q;
    end
    den_d = '0;
    for (int i = 0; i < TAPS; i++) begin
      den_d = den_d + DEN_W'(coef(ktop_q, kmid_q, kbot_q, TAP_W'(i)));
    end
    if (den_d == '0) begin
      den_d = DEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= WW'(RST_W);
      eff_h_q <= H_W'(480);
      total_q <= NW'(RST_TOTAL);
      den_q   <= DEN_W'(9);
      dmag_q  <= DEN_W'(9);
    end else begin
      eff_w_q <= eff_w_d;
      eff_h_q <= eff_h_d;
      total_q <= NW'(eff_w_q) * NW'(eff_h_q);
      den_q   <= den_d;
      dmag_q  <= den_d[DEN_W-1] ? DEN_W'(-den_d) : DEN_W'(den_d);
    end
  end

  // Line stores: upper row shifts down from the middle row at each column
  assign mem_we = (state_q == S_ADV);
  assign up_wd = mid_rd;
  assign mid_wd = pix_q;

  kscv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(col_q),
    .wdata_i(up_wd),
    .raddr_i(col_q),
    .rdata_o(up_rd)
  );

  kscv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(col_q),
    .wdata_i(mid_wd),
    .raddr_i(col_q),
    .rdata_o(mid_rd)
  );

  // Handshakes
  assign pix_i.ready = (state_q == S_IDLE);
  assign in_xfer = pix_i.valid && (state_q == S_IDLE);
  assign is_pix = !pix_i.mode && (n_q < total_q);

  assign pix_o.valid = out_valid_q;
  assign pix_o.red_out = out_data_q[7:0];
  assign pix_o.green_out = out_data_q[15:8];
  assign pix_o.blue_out = out_data_q[23:16];
  assign pix_o.alpha_out = out_data_q[31:24];
  assign pix_o.frame_end = out_last_q;

  // Decode one stream step
  assign valid_res = n_q >= (NW'(eff_w_q) + NW'(1));
  assign border = (col_q == '0) || (col_q == CW'(1)) || (row_q == H_W'(1)) ||
                  (row_q >= eff_h_q);
  assign wrap = (PW'(col_q) + PW'(1)) >= PW'(eff_w_q);
  assign pend_nx = pend_q + (drain_q ? PW'(0) : PW'(1)) - (valid_res ? PW'(1) : PW'(0));

  // Multiply-accumulate one tap over four channels
  assign kc = coef(ktop_q, kmid_q, kbot_q, k_q);
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      logic signed [2*CHAN_W:0] prod;
      prod = $signed({1'b0, win_q[k_q][8*ch +: 8]}) * kc;
      acc_nx[ch] = acc_q[ch] + ACC_W'(prod);
    end
  end

  // One restoring division step per channel
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      logic [DEN_W-1:0] trial;
      logic             qbit;
      trial = {rem_q[ch][DEN_W-2:0], dvd_q[ch][ACC_W-1]};
      qbit = trial >= dmag_q;
      rem_nx[ch] = qbit ? trial - dmag_q : trial;
      dvd_nx[ch] = {dvd_q[ch][ACC_W-2:0], qbit};
      if (neg_q[ch]) begin
        div_res[8*ch +: 8] = '0;
      end else if (dvd_nx[ch] > ACC_W'(255)) begin
        div_res[8*ch +: 8] = 8'hFF;
      end else begin
        div_res[8*ch +: 8] = dvd_nx[ch][7:0];
      end
    end
  end

  // Sequencer: hold state, stream position, window and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      n_q         <= '0;
      pend_q      <= '0;
      drain_q     <= 1'b0;
      try_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      // Load a waiting result, or drop the valid once the result transfers
      if (state_q == S_OUT && (!out_valid_q || pix_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (size_wr) begin
            col_q  <= '0;
            row_q  <= '0;
            n_q    <= '0;
            pend_q <= '0;
            for (int i = 0; i < TAPS; i++) begin
              win_q[i] <= '0;
            end
          end else if (in_xfer) begin
            pix_q   <= is_pix ? {pix_i.alpha_in, pix_i.blue_in, pix_i.green_in,
                                 pix_i.red_in} : '0;
            drain_q <= !is_pix;
            try_q   <= 1'b0;
            if (is_pix || (n_q >= total_q && pend_q != '0)) begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          state_q <= S_ADV;
        end
        S_ADV: begin
          // Shift the window left and load the new column
          for (int r = 0; r < 3; r++) begin
            win_q[3*r]     <= win_q[3*r + 1];
            win_q[3*r + 1] <= win_q[3*r + 2];
          end
          win_q[2] <= up_rd;
          win_q[5] <= mid_rd;
          win_q[8] <= pix_q;
          pend_q <= pend_nx;
          if (valid_res && pend_nx == '0) begin
            // Frame complete: return to the first position
            col_q <= '0;
            row_q <= '0;
            n_q   <= '0;
          end else begin
            if (wrap) begin
              col_q <= '0;
              row_q <= row_q + H_W'(1);
            end else begin
              col_q <= col_q + CW'(1);
            end
            n_q <= n_q + NW'(1);
          end
          if (valid_res) begin
            last_q <= (pend_nx == '0);
            if (border) begin
              res_q   <= win_q[5];
              state_q <= S_OUT;
            end else begin
              k_q     <= '0;
              state_q <= S_MAC;
              for (int ch = 0; ch < 4; ch++) begin
                acc_q[ch] <= '0;
              end
            end
          end else if (drain_q && !try_q) begin
            try_q   <= 1'b1;
            state_q <= S_READ;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_MAC: begin
          for (int ch = 0; ch < 4; ch++) begin
            acc_q[ch] <= acc_nx[ch];
          end
          k_q <= k_q + TAP_W'(1);
          if (k_q == TAP_W'(TAPS - 1)) begin
            // Set up sign and magnitudes for division
            for (int ch = 0; ch < 4; ch++) begin
              neg_q[ch] <= acc_nx[ch][ACC_W-1] != den_q[DEN_W-1];
              dvd_q[ch] <= acc_nx[ch][ACC_W-1] ? ACC_W'(-acc_nx[ch]) : ACC_W'(acc_nx[ch]);
              rem_q[ch] <= '0;
            end
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          for (int ch = 0; ch < 4; ch++) begin
            rem_q[ch] <= rem_nx[ch];
            dvd_q[ch] <= dvd_nx[ch];
          end
          dcnt_q <= dcnt_q + DCW'(1);
          if (dcnt_q == DCW'(ACC_W - 1)) begin
            res_q   <= div_res;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || pix_o.ready) begin
            out_data_q  <= res_q;
            out_last_q  <= last_q;
            if (last_q) begin
              for (int i = 0; i < TAPS; i++) begin
                win_q[i] <= '0;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/kscv_checker.sv -----
// Port-level checker for the convolution filter and its bind to the top level.
`timescale 1ns / 1ps
module kscv_checker
  import kscv_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [PIX_W-1:0]  out_data_i,
  input logic              out_last_i,
  input logic              pready_i,
  input logic [DATA_W-1:0] prdata_i
);

  // Stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  // Configuration port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready dropped");

  // No register is wider than 24 bits
  assert property (@(posedge clk_i) disable iff (!rst_ni) prdata_i[31:24] == '0)
    else $error("read data has bits above the widest register");

endmodule

bind kernel_sum_normalized_convolution_top kscv_checker u_kscv_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(pix_o.valid),
  .out_ready_i(pix_o.ready),
  .out_data_i ({pix_o.alpha_out, pix_o.blue_out, pix_o.green_out, pix_o.red_out}),
  .out_last_i (pix_o.frame_end),
  .pready_i   (pready),
  .prdata_i   (prdata)
);
